>>> src/bpc_pkg.sv
// shared types and constants for the button press classifier
`default_nettype none

package bpc_pkg;

	// fixed field widths
	localparam int KEY_BITS = 5;
	localparam int TS_W     = 32;
	localparam int LONG_W   = 16;
	localparam int MIN_W    = 10;
	localparam int EV_W     = 3;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SHORT  = 1'b1;

	// register reset values
	localparam logic [LONG_W-1:0] LONG_PRESS_RESET = 16'd1000;
	localparam logic [MIN_W-1:0]  MIN_SHORT_RESET  = 10'd15;

	// event codes
	localparam logic [EV_W-1:0] EV_NONE      = 3'd0;
	localparam logic [EV_W-1:0] EV_KEY1_LONG = 3'd1;

	// what one key lane reports to the merge stage
	typedef struct packed {
		logic            fin;
		logic [EV_W-1:0] code;
	} lane_res_t;

endpackage

`default_nettype wire

>>> src/bpc_lane.sv
// one key lane: press state, start time and elapsed-time checks
`default_nettype none

module bpc_lane
	import bpc_pkg::*;
#(
	parameter int LANE_IDX = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              released,
	input  wire logic [TS_W-1:0]   now_ms,
	input  wire logic [LONG_W-1:0] long_press_ms,
	input  wire logic [MIN_W-1:0]  min_short_ms,
	input  wire logic              upd,
	output lane_res_t              res
);

	logic            timing_q;
	logic            finished_q;
	logic [TS_W-1:0] start_q;
	logic [TS_W-1:0] elapsed;
	logic            long_hit;
	logic            short_ok;

	// elapsed time modulo 2^32 and limit checks
	always_comb begin
		elapsed  = now_ms - start_q;
		long_hit = elapsed >= {{(TS_W-LONG_W){1'b0}}, long_press_ms};
		short_ok = elapsed >= {{(TS_W-MIN_W){1'b0}}, min_short_ms};
	end

	// finish test and event code for this key
	always_comb begin
		res.fin = timing_q && !finished_q && (long_hit || released);
		if (long_hit) begin
			res.code = (LANE_IDX == 0) ? EV_KEY1_LONG : EV_NONE;
		end else if (short_ok) begin
			res.code = EV_W'(LANE_IDX + 2);
		end else begin
			res.code = EV_NONE;
		end
	end

	// key state flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q   <= 1'b0;
			finished_q <= 1'b0;
		end else if (upd) begin
			if (!timing_q) begin
				if (!released) begin
					timing_q   <= 1'b1;
					finished_q <= 1'b0;
				end
			end else if (!finished_q) begin
				if (long_hit || released) begin
					finished_q <= 1'b1;
				end
			end else if (released) begin
				timing_q <= 1'b0;
			end
		end
	end

	// press start timestamp
	always_ff @(posedge clk) begin
		if (upd && !timing_q && !released) begin
			start_q <= now_ms;
		end
	end

endmodule

`default_nettype wire

>>> src/bpc_merge.sv
// merge stage: first finishing key wins and gates later lanes
`default_nettype none

module bpc_merge
	import bpc_pkg::*;
#(
	parameter int NUM_KEYS = 5
) (
	input  wire logic                     accept,
	input  lane_res_t [NUM_KEYS-1:0]      res,
	output logic      [NUM_KEYS-1:0]      lane_en,
	output logic      [EV_W-1:0]          code
);

	logic found;

	// priority scan from key 1 upward
	always_comb begin
		found = 1'b0;
		code  = EV_NONE;
		for (int k = 0; k < NUM_KEYS; k++) begin
			lane_en[k] = accept && !found;
			if (!found && res[k].fin) begin
				code  = res[k].code;
				found = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/button_press_classifier_unit.sv
// button press classifier top level: key lanes, merge and output buffer
// an accepted poll's event is registered in the output register, or in the skid entry if that is held
// throughput: one poll per cycle while poll_stall is low; all key lanes compare elapsed time in parallel
//   and the merge picks the first finisher in the same cycle as the state update
// a two-entry output buffer (register plus skid) keeps polls flowing under stall until both entries are full
// reset: every key idle, registers back to 1000 ms and 15 ms, output buffer empty
`default_nettype none

module button_press_classifier_unit
	import bpc_pkg::*;
#(
	parameter int NUM_KEYS = 5
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 poll_valid,
	output logic                      poll_stall,
	input  wire logic [KEY_BITS-1:0]  key_levels,
	input  wire logic [TS_W-1:0]      now_ms,
	output logic                      event_valid,
	input  wire logic                 event_stall,
	output logic [EV_W-1:0]           event_res,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	logic [LONG_W-1:0]        long_q;
	logic [MIN_W-1:0]         min_q;
	logic                     accept;
	logic                     out_pop;
	lane_res_t [NUM_KEYS-1:0] lane_res;
	logic [NUM_KEYS-1:0]      lane_en;
	logic [EV_W-1:0]          code;
	logic                     out_valid_q;
	logic [EV_W-1:0]          out_q;
	logic                     skid_valid_q;
	logic [EV_W-1:0]          skid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_q <= LONG_PRESS_RESET;
			min_q  <= MIN_SHORT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LONG_PRESS: long_q <= cfg_data[LONG_W-1:0];
				REG_MIN_SHORT:  min_q  <= cfg_data[MIN_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign poll_stall  = skid_valid_q;
	assign accept      = poll_valid && !poll_stall;
	assign out_pop     = out_valid_q && !event_stall;
	assign event_valid = out_valid_q;
	assign event_res   = out_q;

	// key lanes
	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		logic released;
		if (k < KEY_BITS) begin : g_pin
			assign released = key_levels[k];
		end else begin : g_nopin
			assign released = 1'b1;
		end
		bpc_lane #(
			.LANE_IDX(k)
		) u_lane (
			.clk          (clk),
			.arst_n       (arst_n),
			.released     (released),
			.now_ms       (now_ms),
			.long_press_ms(long_q),
			.min_short_ms (min_q),
			.upd          (lane_en[k]),
			.res          (lane_res[k])
		);
	end

	// merge of lane results
	bpc_merge #(
		.NUM_KEYS(NUM_KEYS)
	) u_merge (
		.accept (accept),
		.res    (lane_res),
		.lane_en(lane_en),
		.code   (code)
	);

	// output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (out_valid_q && !out_pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_pop) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (out_valid_q && !out_pop) begin
				skid_q <= code;
			end else begin
				out_q <= code;
			end
		end
	end

	function automatic logic [NUM_KEYS-1:0] lane_fin_vec();
		logic [NUM_KEYS-1:0] v;
		for (int k = 0; k < NUM_KEYS; k++) begin
			v[k] = lane_res[k].fin;
		end
		return v;
	endfunction

	// skid entry only ever holds a transaction behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid while output register empty");

	// at most one lane finishes within the lanes allowed to update
	a_one_finisher: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(lane_en & lane_fin_vec()))
		else $error("more than one key finished on one poll");

	// an accepted poll always yields a pending event on the next cycle
	a_accept_gives_event: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted poll produced no event");

	// lanes only update on an accepted poll
	a_no_update_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |-> (lane_en == '0))
		else $error("key lane updated without an accepted poll");

endmodule

`default_nettype wire

>>> bench/bpc_event_checker.sv
// event checker for the button press classifier: predicts each poll's event and compares
`default_nettype none

module bpc_event_checker
	import bpc_pkg::*;
#(
	parameter int NUM_KEYS = 5
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 poll_valid,
	input  wire logic                 poll_stall,
	input  wire logic [KEY_BITS-1:0]  key_levels,
	input  wire logic [TS_W-1:0]      now_ms,
	input  wire logic                 event_valid,
	input  wire logic                 event_stall,
	input  wire logic [EV_W-1:0]      event_res,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output int                        fail_count,
	output int                        pending_events,
	output int                        events_checked,
	output int                        long_events,
	output int                        short_events
);

	// short press of key 1; key k short is this plus k-1
	localparam logic [EV_W-1:0] EV_KEY1_SHORT = 3'd2;
	localparam int REPORT_LIMIT = 10;

	// shadow registers and per-key state
	logic [LONG_W-1:0] long_limit;
	logic [MIN_W-1:0]  min_short;
	logic              key_timing [NUM_KEYS];
	logic              key_done [NUM_KEYS];
	logic [TS_W-1:0]   press_time [NUM_KEYS];

	// events owed by accepted polls, oldest first
	logic [EV_W-1:0]   expected_events [$];
	logic [EV_W-1:0]   want;

	// one poll: walk keys from key 1 up, stop at the first key that finishes
	function automatic logic [EV_W-1:0] classify_poll(input logic [KEY_BITS-1:0] levels,
			input logic [TS_W-1:0] stamp);
		logic            released;
		logic [TS_W-1:0] held;
		logic [EV_W-1:0] code;
		code = EV_NONE;
		for (int k = 0; k < NUM_KEYS; k++) begin
			// keys past the level bits always read released
			released = (k >= KEY_BITS) ? 1'b1 : levels[k];
			if (!key_timing[k]) begin
				if (!released) begin
					press_time[k] = stamp;
					key_timing[k] = 1'b1;
					key_done[k] = 1'b0;
				end
			end else if (!key_done[k]) begin
				held = stamp - press_time[k];
				if (held >= long_limit) begin
					key_done[k] = 1'b1;
					code = (k == 0) ? EV_KEY1_LONG : EV_NONE;
					break;
				end
				if (released) begin
					key_done[k] = 1'b1;
					if (held >= min_short)
						code = EV_KEY1_SHORT + EV_W'(k);
					break;
				end
			end else if (released) begin
				key_timing[k] = 1'b0;
			end
		end
		return code;
	endfunction

	// watch config writes, poll and event transactions
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_limit = LONG_PRESS_RESET;
			min_short = MIN_SHORT_RESET;
			for (int k = 0; k < NUM_KEYS; k++) begin
				key_timing[k] = 1'b0;
				key_done[k] = 1'b0;
				press_time[k] = '0;
			end
			expected_events.delete();
			fail_count = 0;
			pending_events = 0;
			events_checked = 0;
			long_events = 0;
			short_events = 0;
		end else begin
			// event transaction against the oldest owed event
			if (event_valid && !event_stall) begin
				if (expected_events.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("unexpected event transaction: event_res=%0d, no poll waiting",
							event_res);
				end else begin
					want = expected_events.pop_front();
					events_checked++;
					if (want == EV_KEY1_LONG)
						long_events++;
					else if (want >= EV_KEY1_SHORT)
						short_events++;
					if (event_res !== want) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display("event_res mismatch: expected %0d, got %0d", want, event_res);
					end
				end
			end
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_LONG_PRESS: long_limit = cfg_data[LONG_W-1:0];
					REG_MIN_SHORT:  min_short = cfg_data[MIN_W-1:0];
					default: ;
				endcase
			end
			// poll transaction
			if (poll_valid && !poll_stall)
				expected_events.push_back(classify_poll(key_levels, now_ms));
			pending_events = expected_events.size();
		end
	end

endmodule

`default_nettype wire

>>> bench/button_press_classifier_unit_tb.sv
// testbench top for the button press classifier: stimulus, flow control and verdict
`default_nettype none

module button_press_classifier_unit_tb;
	import bpc_pkg::*;

	localparam int NUM_KEYS = 5;
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int PHASE_POLLS = 190;

	// key level patterns (0 means pressed)
	localparam logic [KEY_BITS-1:0] ALL_UP    = 5'b11111;
	localparam logic [KEY_BITS-1:0] ALL_DOWN  = 5'b00000;
	localparam logic [KEY_BITS-1:0] KEY1_DOWN = 5'b11110;
	localparam logic [KEY_BITS-1:0] KEY2_DOWN = 5'b11101;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 poll_valid = 1'b0;
	logic                 poll_stall;
	logic [KEY_BITS-1:0]  key_levels = ALL_UP;
	logic [TS_W-1:0]      now_ms = '0;
	logic                 event_valid;
	logic                 event_stall = 1'b0;
	logic [EV_W-1:0]      event_res;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_LONG_PRESS;
	logic [CFG_W-1:0]     cfg_data = '0;

	int fail_count;
	int pending_events;
	int events_checked;
	int long_events;
	int short_events;

	// stimulus state
	logic [TS_W-1:0]      clock_ms = '0;
	logic [KEY_BITS-1:0]  held_keys = ALL_UP;
	int                   burst_left = 0;
	int                   polls_sent = 0;
	int                   idle_cycles = 0;
	int                   settings_used = 1;
	logic                 squeeze_req = 1'b0;
	logic                 squeeze_done = 1'b0;

	button_press_classifier_unit #(
		.NUM_KEYS(NUM_KEYS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.poll_valid(poll_valid),
		.poll_stall(poll_stall),
		.key_levels(key_levels),
		.now_ms(now_ms),
		.event_valid(event_valid),
		.event_stall(event_stall),
		.event_res(event_res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	bpc_event_checker #(
		.NUM_KEYS(NUM_KEYS)
	) event_check (
		.clk(clk),
		.arst_n(arst_n),
		.poll_valid(poll_valid),
		.poll_stall(poll_stall),
		.key_levels(key_levels),
		.now_ms(now_ms),
		.event_valid(event_valid),
		.event_stall(event_stall),
		.event_res(event_res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending_events(pending_events),
		.events_checked(events_checked),
		.long_events(long_events),
		.short_events(short_events)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((poll_valid && !poll_stall) || (event_valid && !event_stall) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("no transaction for %0d cycles", IDLE_LIMIT);
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver stall pattern, with one long hold-off on request
	initial begin : receiver
		int mode;
		int span;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(10, 80);
			repeat (span) begin
				@(posedge clk);
				if (squeeze_req && !squeeze_done) begin
					event_stall <= 1'b1;
					repeat (HOLD_OFF_CYCLES) @(posedge clk);
					squeeze_done = 1'b1;
				end
				case (mode)
					0: event_stall <= 1'b0;
					1: event_stall <= 1'($urandom_range(0, 1));
					2: event_stall <= ~event_stall;
					default: event_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// offer one poll transaction and wait until it is taken; valid stays high
	task automatic send_poll(input logic [KEY_BITS-1:0] levels, input logic [TS_W-1:0] stamp);
		poll_valid <= 1'b1;
		key_levels <= levels;
		now_ms <= stamp;
		do @(posedge clk); while (poll_stall);
		polls_sent++;
	endtask

	// stop offering and wait until every owed event has come out
	task automatic quiesce();
		poll_valid <= 1'b0;
		@(posedge clk);
		while (pending_events != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// one register write, then a cycle with the write enable low
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// one register setting followed by random polls, mostly held-key sequences
	task automatic run_phase(input logic [LONG_W-1:0] lim, input logic [MIN_W-1:0] min_hold,
			input bit squeeze);
		int scale;
		int gap;
		logic [KEY_BITS-1:0] levels;
		quiesce();
		write_reg(REG_LONG_PRESS, CFG_W'(lim));
		write_reg(REG_MIN_SHORT, CFG_W'(min_hold));
		settings_used++;
		scale = (lim > min_hold) ? int'(lim) : int'(min_hold);
		if (scale < 4)
			scale = 4;
		burst_left = 0;
		for (int i = 0; i < PHASE_POLLS; i++) begin
			// burst and gap shaping; the squeeze burst runs into the hold-off
			if (squeeze && i == 0) begin
				squeeze_req = 1'b1;
				burst_left = 80;
			end else if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					poll_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 40);
			end
			burst_left--;
			// key levels: mostly held keys that change now and then, some noise
			if ($urandom_range(0, 19) == 0) begin
				levels = KEY_BITS'($urandom_range(0, (1 << KEY_BITS) - 1));
			end else begin
				for (int k = 0; k < KEY_BITS; k++)
					if ($urandom_range(0, 5) == 0)
						held_keys[k] = ~held_keys[k];
				levels = held_keys;
			end
			// timestamp steps sized around the current limits
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: clock_ms += $urandom_range(0, scale / 8 + 1);
				5, 6, 7: clock_ms += $urandom_range(0, scale / 2 + 1);
				8: clock_ms += $urandom_range(scale / 2, scale + 2);
				default: begin
					case ($urandom_range(0, 2))
						0: clock_ms = $urandom;
						1: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, scale);
						default: clock_ms += $urandom_range(0, 2);
					endcase
				end
			endcase
			send_poll(levels, clock_ms);
		end
	endtask

	// main sequence
	initial begin : stimulus
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed polls at the reset limits of 1000 ms long and 15 ms short
		send_poll(ALL_UP, 32'd0);
		send_poll(KEY1_DOWN, 32'd100);
		send_poll(KEY1_DOWN, 32'd1100);            // key 1 long
		send_poll(KEY1_DOWN, 32'd1200);            // finished, still held
		send_poll(ALL_UP, 32'd1300);               // rearm
		send_poll(KEY1_DOWN, 32'd1400);
		send_poll(ALL_UP, 32'd1414);               // too short a release
		send_poll(ALL_UP, 32'd1420);
		send_poll(ALL_DOWN, 32'd2000);             // all keys start together
		send_poll(ALL_UP, 32'd2015);               // key 1 short at the exact minimum
		send_poll(ALL_UP, 32'd2020);               // key 1 rearms, key 2 short
		send_poll(ALL_UP, 32'd2030);
		send_poll(ALL_UP, 32'd2040);
		send_poll(ALL_UP, 32'd2050);               // key 5 short
		send_poll(ALL_UP, 32'd2060);
		send_poll(KEY2_DOWN, 32'd3000);
		send_poll(KEY2_DOWN, 32'd4000);            // key 2 long is silent
		send_poll(ALL_UP, 32'd4001);
		send_poll(KEY1_DOWN, 32'hFFFF_FFF0);       // hold across the timestamp wrap
		send_poll(ALL_UP, 32'h0000_0010);
		send_poll(ALL_UP, 32'hFFFF_FFFF);
		send_poll(KEY1_DOWN, 32'd5000);
		send_poll(ALL_UP, 32'd5999);               // just under the long limit
		send_poll(ALL_UP, 32'd6000);

		// random phases over a range of settings, extremes included
		run_phase(16'd1, 10'd0, 1'b0);
		run_phase(16'd65535, 10'd1000, 1'b0);
		run_phase(16'd0, 10'd0, 1'b0);
		run_phase(16'd200, 10'd50, 1'b1);
		run_phase(16'd40, 10'd1000, 1'b0);
		run_phase(16'd1000, 10'd15, 1'b0);
		run_phase(16'd3, 10'd2, 1'b0);
		run_phase(16'd5000, 10'd600, 1'b0);

		quiesce();
		repeat (4) @(posedge clk);

		$display("covered %0d polls over %0d register settings, one long receiver hold-off",
			polls_sent, settings_used);
		$display("checked %0d events: %0d long, %0d short, rest silent",
			events_checked, long_events, short_events);
		if (fail_count == 0 && pending_events == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

>>> button_press_classifier_unit.f
src/bpc_pkg.sv
src/bpc_lane.sv
src/bpc_merge.sv
src/button_press_classifier_unit.sv
bench/bpc_event_checker.sv
bench/button_press_classifier_unit_tb.sv
